// ===== rtl/core/ntts_pkg.sv =====
// ----------------------------------------------------------------------------
// ntts_pkg
// Shared types and constants of the nearest target track selector.
// ----------------------------------------------------------------------------
package ntts_pkg;

    localparam int MAX_CANDIDATES = 64;
    localparam int POS_W          = $clog2(MAX_CANDIDATES + 1);
    localparam int IDX_W          = $clog2(MAX_CANDIDATES);

    localparam int COORD_W  = 16;
    localparam int DIST_W   = 2 * COORD_W + 1;
    localparam int DIM_W    = 12;
    localparam int THR_W    = 8;
    localparam int DET_W    = 8;
    localparam int LOST_W   = 9;
    localparam int TIDX_W   = 6;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [THR_W-1:0] TRACKING_THRESHOLD_RST = 8'd3;
    localparam logic [THR_W-1:0] LOST_THRESHOLD_RST     = 8'd5;
    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST        = 12'd640;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST       = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACKING_THRESHOLD,
        CFG_LOST_THRESHOLD,
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_NO_TARGET,
        ST_TEMP_LOST,
        ST_DETECTED,
        ST_TRACKING
    } status_t;

    typedef struct packed {
        logic               frame_empty;
        logic [COORD_W-1:0] cand_x;
        logic [COORD_W-1:0] cand_y;
        logic               last_in_frame;
    } cand_word_t;

    typedef struct packed {
        status_t            status;
        logic               target_valid;
        logic [TIDX_W-1:0]  target_index;
        logic [COORD_W-1:0] target_x;
        logic [COORD_W-1:0] target_y;
    } result_word_t;

endpackage

// ===== rtl/core/ntts_in_stage.sv =====
// ----------------------------------------------------------------------------
// ntts_in_stage
// Input register: holds one candidate word until the selector takes it.
// ----------------------------------------------------------------------------
module ntts_in_stage
    import ntts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  cand_word_t in_word,
    input  logic       advance,
    output logic       word_valid,
    output cand_word_t word
);

    logic       valid_reg;
    logic       valid_next;
    cand_word_t word_reg;
    logic       load;

    assign in_stall = valid_reg && !advance;
    assign load     = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            word_reg <= in_word;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

// ===== rtl/core/ntts_out_stage.sv =====
// ----------------------------------------------------------------------------
// ntts_out_stage
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module ntts_out_stage
    import ntts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         res_valid,
    input  result_word_t res_word,
    output logic         out_free,
    output logic         out_valid,
    input  logic         out_stall,
    output result_word_t out_word
);

    logic         valid_reg;
    logic         valid_next;
    result_word_t word_reg;

    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_free)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            word_reg <= res_word;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/core/ntts_select.sv =====
// ----------------------------------------------------------------------------
// ntts_select
// Nearest candidate search, track state and configuration registers.
// ----------------------------------------------------------------------------
module ntts_select
    import ntts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 word_valid,
    input  cand_word_t           word,
    input  logic                 out_free,
    output logic                 res_valid,
    output result_word_t         res_word
);

    logic [THR_W-1:0]   tracking_thr_reg;
    logic [THR_W-1:0]   lost_thr_reg;
    logic [DIM_W-1:0]   image_width_reg;
    logic [DIM_W-1:0]   image_height_reg;

    logic               has_track_reg,   has_track_next;
    logic [COORD_W-1:0] track_x_reg,     track_x_next;
    logic [COORD_W-1:0] track_y_reg,     track_y_next;
    logic [DET_W-1:0]   detect_count_reg, detect_count_next;
    logic [LOST_W-1:0]  lost_count_reg,  lost_count_next;
    logic [POS_W-1:0]   frame_pos_reg,   frame_pos_next;
    logic [DIST_W-1:0]  best_dist_reg,   best_dist_next;
    logic [IDX_W-1:0]   best_index_reg,  best_index_next;
    logic [COORD_W-1:0] best_x_reg,      best_x_next;
    logic [COORD_W-1:0] best_y_reg,      best_y_next;

    logic                   step;
    logic [COORD_W-1:0]     ref_x;
    logic [COORD_W-1:0]     ref_y;
    logic [2*COORD_W-1:0]   dx_sq;
    logic [2*COORD_W-1:0]   dy_sq;
    logic [DIST_W-1:0]      cand_dist;
    logic                   in_range;
    logic                   take;
    logic [DET_W-1:0]       detect_inc;
    logic [LOST_W-1:0]      lost_inc;

    function automatic logic [2*COORD_W-1:0] sq_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic [COORD_W-1:0] d;
        begin
            d = (a > b) ? (a - b) : (b - a);
            return d * d;
        end
    endfunction

    assign step = word_valid && out_free;

    // reference: stored track, or image centre (size * 8 in 1/16 pixel)
    assign ref_x = has_track_reg ? track_x_reg : COORD_W'({image_width_reg, 3'b000});
    assign ref_y = has_track_reg ? track_y_reg : COORD_W'({image_height_reg, 3'b000});

    assign dx_sq     = sq_diff(word.cand_x, ref_x);
    assign dy_sq     = sq_diff(word.cand_y, ref_y);
    assign cand_dist = DIST_W'(dx_sq) + DIST_W'(dy_sq);

    assign in_range = frame_pos_reg < POS_W'(MAX_CANDIDATES);
    // strict compare keeps the earliest candidate on a tie
    assign take     = in_range && ((frame_pos_reg == '0) || (cand_dist < best_dist_reg));

    assign detect_inc = (detect_count_reg == '1) ? detect_count_reg
                                                 : detect_count_reg + 1'b1;
    assign lost_inc   = (lost_count_reg == '1) ? lost_count_reg
                                               : lost_count_reg + 1'b1;

    always_comb
    begin
        has_track_next    = has_track_reg;
        track_x_next      = track_x_reg;
        track_y_next      = track_y_reg;
        detect_count_next = detect_count_reg;
        lost_count_next   = lost_count_reg;
        frame_pos_next    = frame_pos_reg;
        best_dist_next    = best_dist_reg;
        best_index_next   = best_index_reg;
        best_x_next       = best_x_reg;
        best_y_next       = best_y_reg;
        res_valid         = 1'b0;
        res_word          = '0;

        if (step)
        begin
            if (word.frame_empty)
            begin
                // drop any partial frame
                frame_pos_next    = '0;
                detect_count_next = '0;
                res_valid         = 1'b1;
                res_word.status   = ST_NO_TARGET;
                if (has_track_reg)
                begin
                    lost_count_next = lost_inc;
                    if (lost_inc <= LOST_W'(lost_thr_reg))
                    begin
                        res_word.status = ST_TEMP_LOST;
                    end
                    else
                    begin
                        has_track_next  = 1'b0;
                        lost_count_next = '0;
                    end
                end
            end
            else
            begin
                if (take)
                begin
                    best_dist_next  = cand_dist;
                    best_index_next = IDX_W'(frame_pos_reg);
                    best_x_next     = word.cand_x;
                    best_y_next     = word.cand_y;
                end
                if (in_range)
                begin
                    frame_pos_next = frame_pos_reg + 1'b1;
                end
                if (word.last_in_frame)
                begin
                    frame_pos_next          = '0;
                    track_x_next            = best_x_next;
                    track_y_next            = best_y_next;
                    has_track_next          = 1'b1;
                    lost_count_next         = '0;
                    detect_count_next       = detect_inc;
                    res_valid               = 1'b1;
                    res_word.status         = (detect_inc >= tracking_thr_reg) ? ST_TRACKING
                                                                               : ST_DETECTED;
                    res_word.target_valid   = 1'b1;
                    res_word.target_index   = TIDX_W'(best_index_next);
                    res_word.target_x       = best_x_next;
                    res_word.target_y       = best_y_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_thr_reg <= TRACKING_THRESHOLD_RST;
            lost_thr_reg     <= LOST_THRESHOLD_RST;
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_TRACKING_THRESHOLD: tracking_thr_reg <= cfg_data[THR_W-1:0];
                CFG_LOST_THRESHOLD:     lost_thr_reg     <= cfg_data[THR_W-1:0];
                CFG_IMAGE_WIDTH:        image_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:       image_height_reg <= cfg_data[DIM_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_track_reg    <= 1'b0;
            track_x_reg      <= '0;
            track_y_reg      <= '0;
            detect_count_reg <= '0;
            lost_count_reg   <= '0;
            frame_pos_reg    <= '0;
            best_dist_reg    <= '0;
            best_index_reg   <= '0;
            best_x_reg       <= '0;
            best_y_reg       <= '0;
        end
        else
        begin
            has_track_reg    <= has_track_next;
            track_x_reg      <= track_x_next;
            track_y_reg      <= track_y_next;
            detect_count_reg <= detect_count_next;
            lost_count_reg   <= lost_count_next;
            frame_pos_reg    <= frame_pos_next;
            best_dist_reg    <= best_dist_next;
            best_index_reg   <= best_index_next;
            best_x_reg       <= best_x_next;
            best_y_reg       <= best_y_next;
        end
    end

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        frame_pos_reg <= POS_W'(MAX_CANDIDATES))
        else $error("frame position beyond candidate limit");

    a_close_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !word.frame_empty && word.last_in_frame) |=>
        (has_track_reg && frame_pos_reg == '0 && lost_count_reg == '0))
        else $error("closed frame did not set up the track");

    a_no_track_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        !has_track_reg |-> (lost_count_reg == '0))
        else $error("loss count runs without a track");

    a_empty_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && word.frame_empty) |=> (detect_count_reg == '0 && frame_pos_reg == '0))
        else $error("empty frame left detect count or position set");

endmodule

// ===== rtl/core/nearest_target_track_selector_core.sv =====
// ----------------------------------------------------------------------------
// nearest_target_track_selector_core
// Path: the input register loads a closing input word on acceptance; selection
// then fills the result register from it once the result register is free, and
// the result word is presented from that register.
// Throughput: one input word per cycle while out_stall lets the result register
// drain; the squared distance and compare against the running best are combinational.
// Reset: configuration returns to 3 / 5 / 640 / 480, track state is cleared.
// ----------------------------------------------------------------------------
module nearest_target_track_selector_core
    import ntts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 frame_empty,
    input  logic [COORD_W-1:0]   cand_x,
    input  logic [COORD_W-1:0]   cand_y,
    input  logic                 last_in_frame,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic                 target_valid,
    output logic [TIDX_W-1:0]    target_index,
    output logic [COORD_W-1:0]   target_x,
    output logic [COORD_W-1:0]   target_y
);

    cand_word_t   in_word;
    cand_word_t   word;
    logic         word_valid;
    logic         out_free;
    logic         res_valid;
    result_word_t res_word;
    result_word_t out_word;

    assign in_word.frame_empty   = frame_empty;
    assign in_word.cand_x        = cand_x;
    assign in_word.cand_y        = cand_y;
    assign in_word.last_in_frame = last_in_frame;

    ntts_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .advance    (out_free),
        .word_valid (word_valid),
        .word       (word)
    );

    ntts_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .word_valid (word_valid),
        .word       (word),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res_word   (res_word)
    );

    ntts_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_word  (res_word),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign status       = out_word.status;
    assign target_valid = out_word.target_valid;
    assign target_index = out_word.target_index;
    assign target_x     = out_word.target_x;
    assign target_y     = out_word.target_y;

endmodule
